// File: hw/rtl/xksd_pkg.sv
`timescale 1ns / 1ps

package xksd_pkg;

  // Width of the byte counter; the model's default is 32.
  localparam int unsigned IndexBits = 32;

  localparam int unsigned WordBits  = 64;
  localparam int unsigned LenBits   = 32;
  localparam int unsigned CfgIdxBits = 1;

  localparam logic [WordBits-1:0] MaskA = 64'h5555_5555_5555_5555;
  localparam logic [WordBits-1:0] MaskB = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WordBits-1:0] MaskC = 64'hFFF7_EEE0_0000_0000;

  localparam logic [WordBits-1:0] KeyReset = 64'd114514;
  localparam logic [LenBits-1:0]  LenReset = 32'd1;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgKeyValue   = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgFileLength = 1'b1;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       last_byte;
  } out_item_t;

  // One keystream step: four shift-xor stages, the first three masked, then the byte index.
  function automatic logic [WordBits-1:0] advance_word(
    input logic [WordBits-1:0]  w_in,
    input logic [IndexBits-1:0] idx
  );
    logic [WordBits-1:0] w;
    w = w_in;
    w = w ^ ((w >> 29) & MaskA);
    w = w ^ ((w << 17) & MaskB);
    w = w ^ ((w << 37) & MaskC);
    w = w ^ (w >> 43);
    w = w ^ WordBits'(idx);
    return w;
  endfunction

endpackage

// File: hw/rtl/xksd_skid.sv
`timescale 1ns / 1ps

// Two-entry output buffer: the result register plus a skid register, so the
// upstream stall comes straight from a flip-flop.
module xksd_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  xksd_pkg::out_item_t in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output xksd_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);

  logic                main_valid_q, main_valid_d;
  logic                skid_valid_q, skid_valid_d;
  xksd_pkg::out_item_t main_q, main_d;
  xksd_pkg::out_item_t skid_q, skid_d;
  logic                accept;
  logic                main_free;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  assign accept    = in_valid_i & ~skid_valid_q;
  assign main_free = ~main_valid_q | ~out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      // The skid entry is older than anything arriving, so it moves up first.
      main_valid_d = skid_valid_q | accept;
      main_d       = skid_valid_q ? skid_q : in_data_i;
      skid_valid_d = 1'b0;
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// File: hw/rtl/xorshift_keystream_byte_decrypt.sv
`timescale 1ns / 1ps

// Channel  | valid      | stall       | payload
// ---------+------------+-------------+--------------------------------------
// input    | in_valid_i | in_stall_o  | in_data_i  (cipher_byte, first_byte)
// output   | out_valid_o| out_stall_i | out_data_o (plain_byte, last_byte)
// config   | cfg_we_i   | (none)      | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while the input is not stalled; its result is
// registered in the output buffer. The keystream word and byte index update in
// the transfer cycle itself, as the step is only a few levels of shift-xor logic.
// Reset restores key 114514, file length 1, and a zero word and index.
// A stalled output holds two results before the input stalls.
module xorshift_keystream_byte_decrypt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  xksd_pkg::in_item_t                  in_data_i,
  output logic                                in_stall_o,
  output logic                                out_valid_o,
  output xksd_pkg::out_item_t                 out_data_o,
  input  logic                                out_stall_i,
  input  logic                                cfg_we_i,
  input  logic [xksd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [xksd_pkg::WordBits-1:0]       cfg_wdata_i
);

  logic [xksd_pkg::WordBits-1:0]  key_q;
  logic [xksd_pkg::LenBits-1:0]   len_q;
  logic [xksd_pkg::WordBits-1:0]  word_q, word_d;
  logic [xksd_pkg::IndexBits-1:0] idx_q, idx_d;
  logic [xksd_pkg::WordBits-1:0]  word_start;
  logic [xksd_pkg::IndexBits-1:0] idx_cur;
  logic [xksd_pkg::IndexBits-1:0] last_idx;
  logic                           in_acc;
  xksd_pkg::out_item_t            result;

  assign in_acc = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= xksd_pkg::KeyReset;
      len_q <= xksd_pkg::LenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xksd_pkg::CfgKeyValue:   key_q <= cfg_wdata_i;
        xksd_pkg::CfgFileLength: len_q <= cfg_wdata_i[xksd_pkg::LenBits-1:0];
        default: ;
      endcase
    end
  end

  // A first byte reseeds from key plus length and restarts the index.
  assign word_start = in_data_i.first_byte
                      ? key_q + xksd_pkg::WordBits'(len_q)
                      : word_q;
  assign idx_cur    = in_data_i.first_byte ? '0 : idx_q;
  assign last_idx   = xksd_pkg::IndexBits'(xksd_pkg::WordBits'(len_q)
                                           - xksd_pkg::WordBits'(1));

  assign word_d = xksd_pkg::advance_word(word_start, idx_cur);
  assign idx_d  = idx_cur + xksd_pkg::IndexBits'(1);

  assign result.plain_byte = in_data_i.cipher_byte ^ word_d[7:0];
  assign result.last_byte  = (idx_cur == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      idx_q  <= '0;
    end else if (in_acc) begin
      word_q <= word_d;
      idx_q  <= idx_d;
    end
  end

  xksd_skid u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (result),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  a_first_restarts_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.first_byte |=> idx_q == xksd_pkg::IndexBits'(1))
    else $error("index did not restart after a first byte");

  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_data_i.first_byte
    |=> idx_q == $past(idx_q) + xksd_pkg::IndexBits'(1))
    else $error("index did not advance by one on a transfer");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i) && $past(out_valid_o))
    else $error("input stall raised without a stalled output");

endmodule
